### hdl/cfmf_pkg.sv
package cfmf_pkg;

    localparam int TAP_COUNT_DEF    = 19;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF   = 16;

    // Half of the symmetric Q1.15 response, center tap first
    localparam int HALF_TAPS = 10;
    localparam logic signed [15:0] HALF_COEFS [HALF_TAPS] = '{
        16'sd11062, 16'sd9043, 16'sd4314, -16'sd180, -16'sd2114,
        -16'sd1364, 16'sd310, 16'sd1028, 16'sd376, -16'sd560
    };

    // Coefficient of tap k, rescaled from Q1.15 to a coef_width-bit fraction
    function automatic logic signed [31:0] coef_at(input int k, input int taps,
                                                   input int coef_width);
        int     d;
        longint c;
        longint r;
        d = k - ((taps - 1) >>> 1);
        if (d < 0)
        begin
            d = -d;
        end
        if (d >= HALF_TAPS)
        begin
            return '0;
        end
        c = longint'(HALF_COEFS[d]);
        if (coef_width >= 16)
        begin
            r = c <<< (coef_width - 16);
        end
        else
        begin
            // round half up, then drop the low bits
            r = (c + (longint'(1) <<< (15 - coef_width))) >>> (16 - coef_width);
        end
        return 32'(r);
    endfunction

endpackage

### hdl/cfmf_cell.sv
module cfmf_cell #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 16,
    parameter int ACC_WIDTH    = 38,
    parameter logic signed [COEF_WIDTH-1:0] COEF = '0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic signed [SAMPLE_WIDTH-1:0] x_i,
    input  logic signed [SAMPLE_WIDTH-1:0] x_q,
    input  logic signed [ACC_WIDTH-1:0]    sum_in_i,
    input  logic signed [ACC_WIDTH-1:0]    sum_in_q,
    output logic signed [ACC_WIDTH-1:0]    sum_i,
    output logic signed [ACC_WIDTH-1:0]    sum_q
);

    localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;

    logic signed [PROD_WIDTH-1:0] prod_i;
    logic signed [PROD_WIDTH-1:0] prod_q;
    logic signed [ACC_WIDTH-1:0]  sum_i_reg;
    logic signed [ACC_WIDTH-1:0]  sum_q_reg;
    logic signed [ACC_WIDTH-1:0]  sum_i_next;
    logic signed [ACC_WIDTH-1:0]  sum_q_next;

    always_comb
    begin
        prod_i     = x_i * COEF;
        prod_q     = x_q * COEF;
        sum_i_next = ACC_WIDTH'(prod_i) + sum_in_i;
        sum_q_next = ACC_WIDTH'(prod_q) + sum_in_q;
    end

    // Partial sums are filter state: cleared at reset, moved only per accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_i_reg <= '0;
            sum_q_reg <= '0;
        end
        else if (advance)
        begin
            sum_i_reg <= sum_i_next;
            sum_q_reg <= sum_q_next;
        end
    end

    assign sum_i = sum_i_reg;
    assign sum_q = sum_q_reg;

endmodule

### hdl/cfmf_out_stage.sv
module cfmf_out_stage #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 16,
    parameter int ACC_WIDTH    = 38
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic                           take,
    input  logic signed [ACC_WIDTH-1:0]    acc_i,
    input  logic signed [ACC_WIDTH-1:0]    acc_q,
    output logic                           valid,
    output logic signed [SAMPLE_WIDTH-1:0] y_i,
    output logic signed [SAMPLE_WIDTH-1:0] y_q
);

    localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS =
        ACC_WIDTH'(1) <<< (COEF_WIDTH - 2);
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX =
        {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN =
        {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic                           valid_reg;
    logic                           valid_next;
    logic signed [SAMPLE_WIDTH-1:0] y_i_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_q_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_i_next;
    logic signed [SAMPLE_WIDTH-1:0] y_q_next;

    function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
        input logic signed [ACC_WIDTH-1:0] acc);
        logic signed [ACC_WIDTH-1:0]           scaled;
        logic [ACC_WIDTH-SAMPLE_WIDTH:0]       top_bits;
        scaled   = (acc + ROUND_BIAS) >>> (COEF_WIDTH - 1);
        top_bits = scaled[ACC_WIDTH-1:SAMPLE_WIDTH-1];
        // in range only when every bit above the kept ones copies the sign
        if ((&top_bits) || !(|top_bits))
        begin
            return scaled[SAMPLE_WIDTH-1:0];
        end
        else if (scaled[ACC_WIDTH-1])
        begin
            return SAT_MIN;
        end
        else
        begin
            return SAT_MAX;
        end
    endfunction

    always_comb
    begin
        y_i_next   = round_sat(acc_i);
        y_q_next   = round_sat(acc_q);
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            y_i_reg <= y_i_next;
            y_q_reg <= y_q_next;
        end
    end

    assign valid = valid_reg;
    assign y_i   = y_i_reg;
    assign y_q   = y_q_reg;

endmodule

### hdl/complex_fir_matched_filter_top.sv
// Complex FIR matched filter: the I and Q parts of each input word pass through the
// same symmetric TAP_COUNT-tap filter, built as a transposed-form row of cells that
// each hold one partial sum per channel and multiply the incoming sample by their own
// fixed coefficient. The full-precision sum is rounded to nearest (ties up) and
// saturated in an output register. One word is taken per clock while s_tready is high;
// cell 0's sum then moves to the output register. The cell row and the output register
// form a two-deep pipeline, so s_tready stays high while a finished result waits, and
// drops only when both stages are full and m_tready is low.
module complex_fir_matched_filter_top
    import cfmf_pkg::*;
#(
    parameter int TAP_COUNT    = TAP_COUNT_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
    localparam int DATA_W      = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // i_sample, q_sample, zero fill
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata    // i_filtered, q_filtered, zero fill
);

    localparam int ACC_WIDTH = SAMPLE_WIDTH + COEF_WIDTH + $clog2(TAP_COUNT) + 1;

    logic signed [SAMPLE_WIDTH-1:0] x_i;
    logic signed [SAMPLE_WIDTH-1:0] x_q;
    logic signed [ACC_WIDTH-1:0]    sum_i [TAP_COUNT+1];
    logic signed [ACC_WIDTH-1:0]    sum_q [TAP_COUNT+1];
    logic                           advance;
    logic                           acc_valid_reg;
    logic                           acc_valid_next;
    logic                           out_load;
    logic                           out_valid;
    logic signed [SAMPLE_WIDTH-1:0] y_i;
    logic signed [SAMPLE_WIDTH-1:0] y_q;

    assign x_i = s_tdata[SAMPLE_WIDTH-1:0];
    assign x_q = s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];

    // The far end of the row sees an empty partial sum
    assign sum_i[TAP_COUNT] = '0;
    assign sum_q[TAP_COUNT] = '0;

    generate
        for (genvar k = 0; k < TAP_COUNT; k++)
        begin : g_cell
            cfmf_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .COEF_WIDTH   (COEF_WIDTH),
                .ACC_WIDTH    (ACC_WIDTH),
                .COEF         (COEF_WIDTH'(coef_at(k, TAP_COUNT, COEF_WIDTH)))
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .x_i      (x_i),
                .x_q      (x_q),
                .sum_in_i (sum_i[k+1]),
                .sum_in_q (sum_q[k+1]),
                .sum_i    (sum_i[k]),
                .sum_q    (sum_q[k])
            );
        end
    endgenerate

    // Cell 0 holds the finished sum; hand it on before the row advances over it
    assign out_load = acc_valid_reg && (!out_valid || m_tready);
    assign s_tready = !acc_valid_reg || out_load;
    assign advance  = s_tvalid && s_tready;

    always_comb
    begin
        acc_valid_next = acc_valid_reg;
        if (advance)
        begin
            acc_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            acc_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_valid_reg <= 1'b0;
        end
        else
        begin
            acc_valid_reg <= acc_valid_next;
        end
    end

    cfmf_out_stage #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH)
    ) u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (out_load),
        .take  (m_tready),
        .acc_i (sum_i[0]),
        .acc_q (sum_q[0]),
        .valid (out_valid),
        .y_i   (y_i),
        .y_q   (y_q)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = DATA_W'({y_q, y_i});

endmodule

### hdl/cfmf_checker.sv
module cfmf_checker #(
    parameter int DATA_W = 32
) (
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       s_acc;
    logic       m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    always_comb
    begin
        pending_next = pending_reg;
        if (s_acc && !m_acc)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (m_acc && !s_acc)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word dropped or changed while stalled");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more words in flight than the pipeline holds");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != 2'd0)
        else $error("result shown with no word in flight");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready && pending_reg == 2'd2)
        else $error("input stalled while the pipeline can move");

endmodule

bind complex_fir_matched_filter_top cfmf_checker #(.DATA_W(DATA_W)) u_cfmf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
